// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked outside reset only
`define MUP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define MUP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MUP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MUP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- src/mup_pkg.sv -----
// ----------------------------------------------------------------------------
// mup_pkg
// Shared types, constants, mu-law expansion and polyphase tap tables.
// ----------------------------------------------------------------------------
package mup_pkg;

  localparam int CHANNELS   = 16;
  localparam int CHAN_W     = 4;
  localparam int HIST_DEPTH = (CHANNELS > (1 << CHAN_W)) ? (1 << CHAN_W) : CHANNELS;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int HIST_ENT   = 1 << HIST_AW;

  localparam int SAMP_W  = 16;
  localparam int NTAPS   = 5;
  localparam int NHIST   = 5;
  localparam int NSAMP   = 9;
  localparam int NPHASE  = 11;
  localparam int PHASE_W = 4;
  localparam int SEL_W   = 4;
  localparam int COEF_W  = 13;
  localparam int PROD_W  = SAMP_W + COEF_W;
  localparam int ACC_W   = 32;
  localparam int SHIFT   = 12;
  localparam int CLAMP_MAX = 32767;

  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(NPHASE - 1);
  localparam logic signed [ACC_W-1:0] CLAMP_HI = ACC_W'(CLAMP_MAX);
  localparam logic signed [ACC_W-1:0] CLAMP_LO = -ACC_W'(CLAMP_MAX);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  typedef logic signed [SAMP_W-1:0] sample_t;
  typedef logic [NHIST-1:0][SAMP_W-1:0] hist_t;   // [0]=h4 .. [4]=h8

  typedef struct packed {
    logic [CHAN_W-1:0]            chan;
    logic [NSAMP-1:0][SAMP_W-1:0] samp;           // s0..s8
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [NTAPS-1:0][COEF_W-1:0] tap_row_t;

  // G.711 mu-law expansion
  function automatic sample_t mulaw_expand(input logic [7:0] code);
    logic [7:0]  u;
    logic [7:0]  base;
    logic [15:0] mag;
    u    = ~code;
    base = {1'b0, u[3:0], 3'b000} + 8'h84;
    mag  = ({8'h00, base} << u[6:4]) - 16'h0084;
    return u[7] ? sample_t'(-mag) : sample_t'(mag);
  endfunction

  // index of the first sample tapped by a phase
  function automatic logic [SEL_W-1:0] tap_first(input logic [PHASE_W-1:0] ph);
    case (ph)
      4'd0:                 return 4'd4;
      4'd1, 4'd2, 4'd3:     return 4'd3;
      4'd4, 4'd5:           return 4'd2;
      4'd6, 4'd7, 4'd8:     return 4'd1;
      default:              return 4'd0;
    endcase
  endfunction

  // coefficients, tap 0 in the low slot
  function automatic tap_row_t tap_row(input logic [PHASE_W-1:0] ph);
    case (ph)
      4'd0: return {13'sd182, -13'sd647, 13'sd3197, 13'sd1753, -13'sd468};
      4'd1: return {-13'sd349, 13'sd1250, 13'sd3573, -13'sd599, 13'sd173};
      4'd2: return {13'sd83, -13'sd279, 13'sd4036, 13'sd356, -13'sd103};
      4'd3: return {13'sd172, -13'sd632, 13'sd2752, 13'sd2262, -13'sd568};
      4'd4: return {-13'sd223, 13'sd778, 13'sd3858, -13'sd479, 13'sd140};
      4'd5: return {13'sd140, -13'sd479, 13'sd3858, 13'sd778, -13'sd223};
      4'd6: return {-13'sd568, 13'sd2262, 13'sd2752, -13'sd632, 13'sd172};
      4'd7: return {-13'sd103, 13'sd356, 13'sd4036, -13'sd279, 13'sd83};
      4'd8: return {13'sd173, -13'sd599, 13'sd3573, 13'sd1250, -13'sd349};
      4'd9: return {-13'sd468, 13'sd1753, 13'sd3197, -13'sd647, 13'sd182};
      default: return '0;
    endcase
  endfunction

endpackage

// ----- src/mup_ifs.sv -----
// ----------------------------------------------------------------------------
// mup_ifs
// Valid/ready channel interfaces for the input groups and output samples.
// ----------------------------------------------------------------------------
interface mup_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] chan;
  logic [7:0] byte_first;
  logic [7:0] byte_second;
  logic [7:0] byte_third;
  logic [7:0] byte_fourth;

  modport source (output valid, chan, byte_first, byte_second, byte_third, byte_fourth,
                  input ready);
  modport sink   (input valid, chan, byte_first, byte_second, byte_third, byte_fourth,
                  output ready);
endinterface

interface mup_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic [3:0]         out_chan;
  logic [3:0]         phase;
  logic               last_of_run;

  modport source (output valid, pcm_sample, out_chan, phase, last_of_run, input ready);
  modport sink   (input valid, pcm_sample, out_chan, phase, last_of_run, output ready);
endinterface

// ----- src/mup_fifo.sv -----
// ----------------------------------------------------------------------------
// mup_fifo
// Short queue of decoded groups between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mup_fifo import mup_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  entry_t  wr_data,
  input  logic    pop,
  output entry_t  rd_data,
  output q_stat_t stat
);

  entry_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `MUP_ASSERT(a_no_underflow, clk, rst_n, pop |-> !stat.empty, "pop from empty queue")
  `MUP_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= (Q_AW+1)'(Q_DEPTH), "queue count overrun")
  `MUP_ASSERT(a_push_fills, clk, rst_n, (push && !pop) |=> !stat.empty, "entry lost on push")

endmodule

// ----- src/mup_front.sv -----
// ----------------------------------------------------------------------------
// mup_front
// Accepts groups, expands the mu-law bytes, reads and updates the channel
// history and queues the nine samples for the filter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mup_front import mup_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mup_in_if.sink      in_bus,
  input  q_stat_t     stat,
  output logic        push,
  output entry_t      wr_data
);

  hist_t              hist_r [HIST_ENT];
  logic [HIST_AW-1:0] hidx;
  logic               accept;
  logic               chan_ok;

  assign in_bus.ready = !stat.full;
  assign accept       = in_bus.valid && in_bus.ready;
  // channels past the configured count are dropped
  assign chan_ok      = (32'(in_bus.chan) < CHANNELS);
  assign push         = accept && chan_ok;
  assign hidx         = in_bus.chan[HIST_AW-1:0];

  always_comb begin
    wr_data.chan    = in_bus.chan;
    wr_data.samp[0] = mulaw_expand(in_bus.byte_fourth);
    wr_data.samp[1] = mulaw_expand(in_bus.byte_third);
    wr_data.samp[2] = mulaw_expand(in_bus.byte_second);
    wr_data.samp[3] = mulaw_expand(in_bus.byte_first);
    for (int i = 0; i < NHIST; i++) begin
      wr_data.samp[NSAMP-NHIST+i] = hist_r[hidx][i];
    end
  end

  // new history: h4..h7 = d0..d3, h8 = old h4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < HIST_ENT; e++) begin
        hist_r[e] <= '0;
      end
    end else if (push) begin
      hist_r[hidx] <= wr_data.samp[NHIST-1:0];
    end
  end

  `MUP_ASSERT(a_push_room, clk, rst_n, push |-> !stat.full, "push into full queue")
  `MUP_ASSERT(a_drop_bad_chan, clk, rst_n, (accept && !chan_ok) |-> !push,
              "out-of-range channel queued")
  `MUP_ASSERT_ALWAYS(a_reset_ready, clk, !rst_n |=> !stat.full, "queue full after reset")

endmodule

// ----- src/mup_back.sv -----
// ----------------------------------------------------------------------------
// mup_back
// Runs the eleven phases of one queued group: tap select and multiply, then
// sum, floor shift and clamp into the output register; last phase passes s2.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mup_back import mup_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  entry_t      rd_data,
  input  q_stat_t     stat,
  output logic        pop,
  mup_out_if.source   out_bus
);

  logic [PHASE_W-1:0] ph_r, ph_nxt;
  logic               en;
  logic               issue;

  // stage 1
  logic                     s1_v_r;
  logic signed [PROD_W-1:0] s1_prod_r [NTAPS];
  logic signed [PROD_W-1:0] prod_nxt  [NTAPS];
  logic [CHAN_W-1:0]        s1_chan_r;
  logic [PHASE_W-1:0]       s1_ph_r;
  logic                     s1_pass_r;
  sample_t                  s1_raw_r;

  // output register
  logic                     o_valid_r;
  sample_t                  o_pcm_r;
  logic [CHAN_W-1:0]        o_chan_r;
  logic [PHASE_W-1:0]       o_ph_r;
  logic                     o_last_r;

  logic [SEL_W-1:0]         first;
  logic [SEL_W-1:0]         sel [NTAPS];
  tap_row_t                 row;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  shifted;
  sample_t                  pcm_nxt;

  assign en     = !o_valid_r || out_bus.ready;
  assign issue  = en && !stat.empty;
  assign pop    = issue && (ph_r == LAST_PHASE);
  assign ph_nxt = (ph_r == LAST_PHASE) ? '0 : ph_r + 1'b1;

  always_comb begin
    first = tap_first(ph_r);
    row   = tap_row(ph_r);
    for (int j = 0; j < NTAPS; j++) begin
      sel[j]      = first + SEL_W'(j);
      prod_nxt[j] = $signed(rd_data.samp[sel[j]]) * $signed(row[j]);
    end
  end

  always_comb begin
    acc = '0;
    for (int j = 0; j < NTAPS; j++) begin
      acc = acc + ACC_W'(s1_prod_r[j]);
    end
    shifted = acc >>> SHIFT;   // floor toward minus infinity
    if (s1_pass_r) begin
      pcm_nxt = s1_raw_r;
    end else if (shifted > CLAMP_HI) begin
      pcm_nxt = sample_t'(CLAMP_HI);
    end else if (shifted < CLAMP_LO) begin
      pcm_nxt = sample_t'(CLAMP_LO);
    end else begin
      pcm_nxt = sample_t'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= '0;
      s1_v_r    <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        ph_r <= ph_nxt;
      end
      if (en) begin
        s1_v_r    <= issue;
        o_valid_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      for (int j = 0; j < NTAPS; j++) begin
        s1_prod_r[j] <= prod_nxt[j];
      end
      s1_chan_r <= rd_data.chan;
      s1_ph_r   <= ph_r;
      s1_pass_r <= (ph_r == LAST_PHASE);
      s1_raw_r  <= sample_t'(rd_data.samp[2]);
    end
    if (en && s1_v_r) begin
      o_pcm_r  <= pcm_nxt;
      o_chan_r <= s1_chan_r;
      o_ph_r   <= s1_ph_r;
      o_last_r <= s1_pass_r;
    end
  end

  assign out_bus.valid       = o_valid_r;
  assign out_bus.pcm_sample  = o_pcm_r;
  assign out_bus.out_chan    = o_chan_r;
  assign out_bus.phase       = o_ph_r;
  assign out_bus.last_of_run = o_last_r;

  `MUP_ASSERT(a_pop_at_last, clk, rst_n, pop |-> (ph_r == LAST_PHASE), "pop mid-run")
  `MUP_ASSERT(a_stall_holds_phase, clk, rst_n, !en |=> $stable(ph_r), "phase moved in stall")
  `MUP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!o_valid_r && !s1_v_r),
                     "pipeline valid after reset")

endmodule

// ----- src/mulaw_upsample_4_to_11_unit.sv -----
// ----------------------------------------------------------------------------
// mulaw_upsample_4_to_11_unit
// mu-law 4-to-11 polyphase interpolator, per-channel history of five samples.
//
//   channel   dir  transaction                       fields
//   in_bus    in   one group of four mu-law bytes    chan, byte_first..fourth
//   out_bus   out  one linear sample                 pcm_sample, out_chan,
//                                                    phase, last_of_run
//
// The back end issues one phase per cycle through its 5-tap multiply stage,
// unless the queue is empty or the output stalls, into the output register.
// The front takes a group every cycle while the two-entry queue has room.
// Synchronous active-low reset clears the history to zero and empties the
// pipeline. A stalled output freezes the back end; the front fills the queue.
// ----------------------------------------------------------------------------
module mulaw_upsample_4_to_11_unit import mup_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mup_in_if.sink    in_bus,
  mup_out_if.source out_bus
);

  logic    push;
  logic    pop;
  entry_t  wr_data;
  entry_t  rd_data;
  q_stat_t stat;

  mup_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .stat    (stat),
    .push    (push),
    .wr_data (wr_data)
  );

  mup_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_data),
    .pop     (pop),
    .rd_data (rd_data),
    .stat    (stat)
  );

  mup_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_data (rd_data),
    .stat    (stat),
    .pop     (pop),
    .out_bus (out_bus)
  );

endmodule

// ----- tb/tb_mulaw_upsample_4_to_11_unit.sv -----
// ----------------------------------------------------------------------------
// tb_mulaw_upsample_4_to_11_unit
// Self-checking bench for the mu-law 4-to-11 interpolator. A driver sends
// groups of four mu-law bytes from a pending queue, a scoreboard model
// computes the eleven samples of each accepted group, and a monitor compares
// every output transaction against the oldest expected sample. Both sides
// idle at random; directed groups hit code extremes and filter saturation.
// ----------------------------------------------------------------------------
module tb_mulaw_upsample_4_to_11_unit import mup_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_GROUPS = 460;
  localparam int IDLE_LIMIT    = 2000;
  localparam int TAIL_CYCLES   = 30;
  localparam int PHASES        = 11;
  localparam int FILTERS       = 10;

  typedef struct packed {
    logic [3:0] chan;
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
    logic [7:0] fourth;
  } mulaw_group_t;

  typedef struct packed {
    sample_t    pcm;
    logic [3:0] chan;
    logic [3:0] phase;
    logic       last;
  } pcm_expect_t;

  logic clk;
  logic rst_n;

  mup_in_if  in_bus ();
  mup_out_if out_bus ();

  mulaw_upsample_4_to_11_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // filter taps, tap 0 applied to sample index fir_base[p]
  const int fir_coef [FILTERS][5] = '{
    '{-468, 1753, 3197, -647, 182},
    '{173, -599, 3573, 1250, -349},
    '{-103, 356, 4036, -279, 83},
    '{-568, 2262, 2752, -632, 172},
    '{140, -479, 3858, 778, -223},
    '{-223, 778, 3858, -479, 140},
    '{172, -632, 2752, 2262, -568},
    '{83, -279, 4036, 356, -103},
    '{-349, 1250, 3573, -599, 173},
    '{182, -647, 3197, 1753, -468}
  };
  const int fir_base [FILTERS] = '{4, 3, 3, 3, 2, 2, 1, 1, 1, 0};

  sample_t       chan_hist [CHANNELS][5];   // [0] newest .. [4] oldest
  mulaw_group_t  group_q[$];
  pcm_expect_t   pcm_expect_q[$];
  mulaw_group_t  nxt_group;
  pcm_expect_t   want;

  int  groups_total;
  int  groups_sent;
  int  samples_seen;
  int  clamp_hits;
  int  fail_cnt;
  int  idle_cycles;
  int  in_gap;
  int  out_stall;
  int  st;
  bit  in_calm;
  bit  out_calm;

  function automatic int expand_mulaw(logic [7:0] code);
    logic [7:0] inv;
    int         mag;
    inv = ~code;
    mag = ((int'(inv[3:0]) << 3) + 132) << inv[6:4];
    return inv[7] ? 132 - mag : mag - 132;
  endfunction

  // computes the eleven samples of one group and advances its channel history
  function automatic void interpolate_group(mulaw_group_t g);
    int s [9];
    int acc;
    int v;
    pcm_expect_t e;
    if (int'(g.chan) >= CHANNELS) return;
    s[0] = expand_mulaw(g.fourth);
    s[1] = expand_mulaw(g.third);
    s[2] = expand_mulaw(g.second);
    s[3] = expand_mulaw(g.first);
    for (int j = 0; j < 5; j++) s[4 + j] = chan_hist[g.chan][j];
    for (int p = 0; p < PHASES; p++) begin
      if (p < FILTERS) begin
        acc = 0;
        for (int j = 0; j < 5; j++) acc += fir_coef[p][j] * s[fir_base[p] + j];
        v = acc >>> 12;
        if (v > 32767) begin
          v = 32767;
          clamp_hits++;
        end else if (v < -32767) begin
          v = -32767;
          clamp_hits++;
        end
      end else begin
        v = s[2];
      end
      e.pcm   = sample_t'(v);
      e.chan  = g.chan;
      e.phase = 4'(p);
      e.last  = (p == PHASES - 1);
      pcm_expect_q.push_back(e);
    end
    chan_hist[g.chan][4] = sample_t'(s[4]);
    chan_hist[g.chan][3] = sample_t'(s[3]);
    chan_hist[g.chan][2] = sample_t'(s[2]);
    chan_hist[g.chan][1] = sample_t'(s[1]);
    chan_hist[g.chan][0] = sample_t'(s[0]);
  endfunction

  function automatic void add_group(int ch, int b1, int b2, int b3, int b4);
    mulaw_group_t g;
    g.chan   = 4'(ch);
    g.first  = 8'(b1);
    g.second = 8'(b2);
    g.third  = 8'(b3);
    g.fourth = 8'(b4);
    group_q.push_back(g);
  endfunction

  // biased toward full-scale codes so the filters saturate now and then
  function automatic int pick_code();
    int picks [6] = '{8'h00, 8'h80, 8'h01, 8'h81, 8'h7F, 8'hFF};
    if ($urandom_range(0, 7) == 0) return picks[$urandom_range(0, 5)];
    return $urandom_range(0, 255);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap       <= 0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (in_bus.valid) begin
        interpolate_group('{chan: in_bus.chan, first: in_bus.byte_first,
                            second: in_bus.byte_second, third: in_bus.byte_third,
                            fourth: in_bus.byte_fourth});
        groups_sent++;
      end
      if (in_gap > 0) begin
        in_bus.valid <= 1'b0;
        in_gap       <= in_gap - 1;
      end else if (group_q.size() > 0) begin
        nxt_group = group_q.pop_front();
        in_bus.chan        <= nxt_group.chan;
        in_bus.byte_first  <= nxt_group.first;
        in_bus.byte_second <= nxt_group.second;
        in_bus.byte_third  <= nxt_group.third;
        in_bus.byte_fourth <= nxt_group.fourth;
        in_bus.valid       <= 1'b1;
        if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
        in_gap <= in_calm ? 0 : $urandom_range(0, 10);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // output monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_stall     <= 0;
    end else if (out_bus.valid && out_bus.ready) begin
      samples_seen++;
      if (pcm_expect_q.size() == 0) begin
        $error("unexpected sample: chan %0d phase %0d pcm %0d",
               out_bus.out_chan, out_bus.phase, out_bus.pcm_sample);
        fail_cnt++;
      end else begin
        want = pcm_expect_q.pop_front();
        if (out_bus.pcm_sample !== want.pcm) begin
          $error("pcm_sample: expected %0d, got %0d", want.pcm, out_bus.pcm_sample);
          fail_cnt++;
        end
        if (out_bus.out_chan !== want.chan) begin
          $error("out_chan: expected %0d, got %0d", want.chan, out_bus.out_chan);
          fail_cnt++;
        end
        if (out_bus.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, out_bus.phase);
          fail_cnt++;
        end
        if (out_bus.last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_bus.last_of_run);
          fail_cnt++;
        end
      end
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      st = out_calm ? 0 : $urandom_range(0, 10);
      if (st > 0) begin
        out_bus.ready <= 1'b0;
        out_stall     <= st - 1;
      end
    end else if (!out_bus.ready) begin
      if (out_stall == 0) out_bus.ready <= 1'b1;
      else out_stall <= out_stall - 1;
    end
  end

  // cycles without any transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.chan         = '0;
    in_bus.byte_first   = '0;
    in_bus.byte_second  = '0;
    in_bus.byte_third   = '0;
    in_bus.byte_fourth  = '0;
    out_bus.ready       = 1'b0;
    foreach (chan_hist[c, k]) chan_hist[c][k] = '0;

    // directed: zeros of both signs, full scale, saturation, rounding of negatives
    add_group(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_group(15, 8'h7F, 8'h7F, 8'h7F, 8'h7F);
    add_group(1, 8'h80, 8'h80, 8'h80, 8'h80);
    add_group(1, 8'h00, 8'h00, 8'h00, 8'h00);
    add_group(1, 8'h80, 8'h80, 8'h80, 8'h80);
    add_group(2, 8'h80, 8'h00, 8'h80, 8'h80);   // sets up positive overflow
    add_group(2, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    add_group(3, 8'h00, 8'h80, 8'h00, 8'h00);   // sets up negative overflow
    add_group(3, 8'h80, 8'hFF, 8'hFF, 8'hFF);
    add_group(4, 8'h7E, 8'hFE, 8'h7E, 8'h7D);
    add_group(4, 8'h7E, 8'h7E, 8'h7E, 8'h7E);
    add_group(5, 8'h55, 8'hAA, 8'h0F, 8'hF0);
    add_group(10, 8'h33, 8'hCC, 8'h01, 8'h81);
    add_group(7, 8'hF0, 8'h0F, 8'hAA, 8'h55);
    add_group(8, 8'h00, 8'h80, 8'h7F, 8'hFF);
    add_group(6, 8'h01, 8'h02, 8'h04, 8'h08);
    add_group(9, 8'h10, 8'h20, 8'h40, 8'h80);
    for (int i = 0; i < 4; i++) add_group(11, 8'h80, 8'h00, 8'h80, 8'h00);
    add_group(12, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_group(13, 8'h80, 8'h00, 8'h80, 8'h00);
    add_group(14, 8'h8F, 8'h9F, 8'hEF, 8'h0E);

    // random: mostly a few busy channels so histories carry over
    for (int i = 0; i < RANDOM_GROUPS; i++)
      add_group(($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(0, 15),
                pick_code(), pick_code(), pick_code(), pick_code());
    groups_total = group_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (!(groups_sent == groups_total && pcm_expect_q.size() == 0) &&
           idle_cycles < IDLE_LIMIT)
      @(posedge clk);

    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d of %0d groups sent, %0d samples outstanding",
               groups_sent, groups_total, pcm_expect_q.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (pcm_expect_q.size() != 0) begin
        $error("%0d expected samples never arrived", pcm_expect_q.size());
        fail_cnt++;
      end
      $display("Sent %0d mu-law groups over 16 channels, checked %0d output samples",
               groups_sent, samples_seen);
      $display("Filter outputs clamped at full scale: %0d", clamp_hits);
      if (fail_cnt == 0)
        $display("TEST PASSED");
      else
        $display("TEST FAILED");
      $finish;
    end
  end

endmodule

// ----- mulaw_upsample_4_to_11_unit.f -----
+incdir+src
src/mup_pkg.sv
src/mup_ifs.sv
src/mup_fifo.sv
src/mup_front.sv
src/mup_back.sv
src/mulaw_upsample_4_to_11_unit.sv
tb/tb_mulaw_upsample_4_to_11_unit.sv
